### rtl/core/plc_pkg.sv
// Shared types and constants of the per-address connection limiter.
package plc_pkg;

    localparam int ADDR_W      = 32;
    localparam int SID_W       = 16;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 3;
    localparam int LIMIT_W     = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [STATUS_W-1:0] STAT_OK               = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_TOO_MANY_CLIENTS = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TOO_MANY_ADDR    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN_SESSION  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIENTS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_ADDRESS = 1'd1;

    localparam logic MODE_OPEN  = 1'b0;
    localparam logic MODE_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_SETDATA = 2'd2,
        OP_REMOVE  = 2'd3
    } tbl_op_t;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] source_address;
        logic [SID_W-1:0]  session_id;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  address_count;
        logic [COUNT_W-1:0]  client_count;
    } out_word_t;

endpackage

### rtl/core/per_address_connection_limiter.sv
// Top level: sequencer over the address and session cell rows.
//
//  channel | ports                        | word
//  --------+------------------------------+----------------------------------
//  input   | s_valid s_ready s_data       | mode, source_address, session_id
//  result  | m_valid m_ready m_data       | status, address_count, client_count
//  config  | cfg_valid cfg_ready cfg_*    | register index, 8-bit value
//
//  Each word passes through accept, session lookup, address key load, address
//  lookup, table update. The two lookups run one after the other through the
//  registered match reduction of each cell row. No clearing pass after reset:
//  the fill counts mark every cell empty. A result waiting on m_ready holds
//  the update step; the next word is accepted once the update has issued.
module per_address_connection_limiter #(
    parameter int ADDRESS_SLOTS   = 64,
    parameter int SESSION_SLOTS   = 64,
    parameter int SESSION_ID_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  plc_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output plc_pkg::out_word_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plc_pkg::LIMIT_W-1:0]       cfg_data
);
    import plc_pkg::*;

    localparam int SID_KEY_W = (SESSION_ID_BITS < SID_W) ? SESSION_ID_BITS : SID_W;
    localparam int A_IDX_W   = $clog2(ADDRESS_SLOTS);
    localparam int A_FILL_W  = $clog2(ADDRESS_SLOTS + 1);
    localparam int S_IDX_W   = $clog2(SESSION_SLOTS);
    localparam int S_FILL_W  = $clog2(SESSION_SLOTS + 1);
    localparam logic [A_FILL_W-1:0] A_FULL = A_FILL_W'(ADDRESS_SLOTS);
    localparam logic [S_FILL_W-1:0] S_FULL = S_FILL_W'(SESSION_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK1  = 5'b00010,
        S_LOOK2  = 5'b00100,
        S_LOOK3  = 5'b01000,
        S_UPDATE = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   mode_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [SID_KEY_W-1:0]   sid_reg;
    logic [ADDR_W-1:0]      akey_reg, akey_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [LIMIT_W-1:0]     max_clients_reg;
    logic [LIMIT_W-1:0]     max_per_reg;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_data_reg, m_data_next;

    tbl_op_t                a_op, s_op;
    logic [A_IDX_W-1:0]     a_pos;
    logic [S_IDX_W-1:0]     s_pos;
    logic [COUNT_W-1:0]     a_wr_data;
    logic                   a_hit, s_hit;
    logic [A_IDX_W-1:0]     a_idx;
    logic [S_IDX_W-1:0]     s_idx;
    logic [COUNT_W-1:0]     a_cnt;
    logic [ADDR_W-1:0]      s_addr;
    logic [A_FILL_W-1:0]    a_fill;
    logic [S_FILL_W-1:0]    s_fill;

    logic                   fire;
    logic                   a_full, s_full;
    logic [COUNT_W-1:0]     acount;
    logic [STATUS_W-1:0]    status;

    plc_table #(
        .SLOTS  (ADDRESS_SLOTS),
        .KEY_W  (ADDR_W),
        .DATA_W (COUNT_W)
    ) u_addr_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (a_op),
        .pos      (a_pos),
        .wr_key   (addr_reg),
        .wr_data  (a_wr_data),
        .look_key (akey_reg),
        .hit      (a_hit),
        .idx      (a_idx),
        .data     (a_cnt),
        .fill     (a_fill)
    );

    plc_table #(
        .SLOTS  (SESSION_SLOTS),
        .KEY_W  (SID_KEY_W),
        .DATA_W (ADDR_W)
    ) u_sess_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (s_op),
        .pos      (s_pos),
        .wr_key   (sid_reg),
        .wr_data  (addr_reg),
        .look_key (sid_reg),
        .hit      (s_hit),
        .idx      (s_idx),
        .data     (s_addr),
        .fill     (s_fill)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign fire      = (state_reg == S_UPDATE) && (!m_valid_reg || m_ready);
    assign a_full    = !a_hit && (a_fill == A_FULL);
    assign s_full    = !s_hit && (s_fill == S_FULL);

    always_comb begin
        state_next = state_reg;
        akey_next  = akey_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOK1;
                    akey_next  = s_data.source_address;
                end
            end
            S_LOOK1: state_next = S_LOOK2;
            S_LOOK2: begin
                state_next = S_LOOK3;
                if (mode_reg == MODE_CLOSE) begin
                    akey_next = s_addr;
                end
            end
            S_LOOK3: state_next = S_UPDATE;
            S_UPDATE: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        a_op       = OP_NONE;
        s_op       = OP_NONE;
        a_pos      = a_idx;
        s_pos      = s_idx;
        a_wr_data  = a_cnt;
        total_next = total_reg;
        acount     = '0;
        status     = STAT_OK;
        if (mode_reg == MODE_OPEN) begin
            if (a_full || s_full) begin
                status = STAT_TABLE_FULL;
                acount = a_hit ? a_cnt : '0;
            end else begin
                total_next = (total_reg == COUNT_MAX) ? total_reg
                                                      : total_reg + COUNT_W'(1);
                if (!a_hit) begin
                    a_op      = OP_WRITE;
                    a_pos     = a_fill[A_IDX_W-1:0];
                    a_wr_data = COUNT_W'(1);
                end else begin
                    a_op      = OP_SETDATA;
                    a_wr_data = (a_cnt == COUNT_MAX) ? a_cnt : a_cnt + COUNT_W'(1);
                end
                acount = a_wr_data;
                if (!s_hit) begin
                    s_op  = OP_WRITE;
                    s_pos = s_fill[S_IDX_W-1:0];
                end else begin
                    s_op = OP_SETDATA;
                end
                if ((max_clients_reg != '0) && ({1'b0, total_next} > max_clients_reg)) begin
                    status = STAT_TOO_MANY_CLIENTS;
                end else if ((max_per_reg != '0) && ({1'b0, acount} > max_per_reg)) begin
                    status = STAT_TOO_MANY_ADDR;
                end
            end
        end else begin
            total_next = (total_reg == '0) ? total_reg : total_reg - COUNT_W'(1);
            if (!s_hit) begin
                status = STAT_UNKNOWN_SESSION;
            end else begin
                s_op = OP_REMOVE;
                if (a_hit && (a_cnt != '0)) begin
                    a_wr_data = a_cnt - COUNT_W'(1);
                    acount    = a_wr_data;
                    a_op      = (a_wr_data == '0) ? OP_REMOVE : OP_SETDATA;
                end
            end
        end
        if (!fire) begin
            a_op       = OP_NONE;
            s_op       = OP_NONE;
            total_next = total_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (fire) begin
            m_valid_next              = 1'b1;
            m_data_next.status        = status;
            m_data_next.address_count = acount;
            m_data_next.client_count  = total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            total_reg       <= '0;
            max_clients_reg <= '0;
            max_per_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MAX_CLIENTS:     max_clients_reg <= cfg_data;
                    REG_MAX_PER_ADDRESS: max_per_reg     <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        akey_reg   <= akey_next;
        m_data_reg <= m_data_next;
        if (s_valid && s_ready) begin
            mode_reg <= s_data.mode;
            addr_reg <= s_data.source_address;
            sid_reg  <= s_data.session_id[SID_KEY_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_LOOK1))
        else $error("accepted word did not start lookup");

    a_result_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_UPDATE))
        else $error("result raised outside update step");

    a_update_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (m_valid && (state_reg == S_IDLE)))
        else $error("update did not post a result");

endmodule

### rtl/core/plc_cell.sv
// One table cell: holds a key and its data, compares against the lookup key.
module plc_cell #(
    parameter int KEY_W  = 32,
    parameter int DATA_W = 7,
    parameter int IDX_W  = 6,
    parameter int FILL_W = 7,
    parameter int INDEX  = 0
) (
    input  logic              aclk,
    input  plc_pkg::tbl_op_t  op,
    input  logic [IDX_W-1:0]  pos,
    input  logic [FILL_W-1:0] fill,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [KEY_W-1:0]  up_key,
    input  logic [DATA_W-1:0] up_data,
    input  logic [KEY_W-1:0]  look_key,
    output logic [KEY_W-1:0]  key,
    output logic [DATA_W-1:0] data,
    output logic              match
);
    import plc_pkg::*;

    localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(INDEX);
    localparam logic [FILL_W-1:0] MY_FILL = FILL_W'(INDEX);

    logic [KEY_W-1:0]  key_reg,  key_next;
    logic [DATA_W-1:0] data_reg, data_next;

    always_comb begin
        key_next  = key_reg;
        data_next = data_reg;
        unique case (op)
            OP_NONE: begin
            end
            OP_WRITE: begin
                if (pos == MY_IDX) begin
                    key_next  = wr_key;
                    data_next = wr_data;
                end
            end
            OP_SETDATA: begin
                if (pos == MY_IDX) begin
                    data_next = wr_data;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= pos) begin
                    key_next  = up_key;
                    data_next = up_data;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key   = key_reg;
    assign data  = data_reg;
    assign match = (MY_FILL < fill) && (key_reg == look_key);

endmodule

### rtl/core/plc_table.sv
// Row of cells kept packed from slot zero, with fill count and registered lookup.
module plc_table #(
    parameter int SLOTS  = 64,
    parameter int KEY_W  = 32,
    parameter int DATA_W = 7,
    parameter int IDX_W  = $clog2(SLOTS),
    parameter int FILL_W = $clog2(SLOTS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  plc_pkg::tbl_op_t  op,
    input  logic [IDX_W-1:0]  pos,
    input  logic [KEY_W-1:0]  wr_key,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [KEY_W-1:0]  look_key,
    output logic              hit,
    output logic [IDX_W-1:0]  idx,
    output logic [DATA_W-1:0] data,
    output logic [FILL_W-1:0] fill
);
    import plc_pkg::*;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SLOTS);

    logic [KEY_W-1:0]  cell_key  [SLOTS+1];
    logic [DATA_W-1:0] cell_data [SLOTS+1];
    logic [SLOTS-1:0]  cell_match;

    logic              hit_reg,  hit_next;
    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign cell_key[SLOTS]  = '0;
    assign cell_data[SLOTS] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        plc_cell #(
            .KEY_W  (KEY_W),
            .DATA_W (DATA_W),
            .IDX_W  (IDX_W),
            .FILL_W (FILL_W),
            .INDEX  (i)
        ) u_cell (
            .aclk     (aclk),
            .op       (op),
            .pos      (pos),
            .fill     (fill_reg),
            .wr_key   (wr_key),
            .wr_data  (wr_data),
            .up_key   (cell_key[i+1]),
            .up_data  (cell_data[i+1]),
            .look_key (look_key),
            .key      (cell_key[i]),
            .data     (cell_data[i]),
            .match    (cell_match[i])
        );
    end

    // keys are unique among valid cells, so the hit collapses by OR
    always_comb begin
        hit_next  = 1'b0;
        idx_next  = '0;
        data_next = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (cell_match[i]) begin
                hit_next  = 1'b1;
                idx_next  = idx_next | IDX_W'(i);
                data_next = data_next | cell_data[i];
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        unique case (op)
            OP_WRITE:   fill_next = fill_reg + FILL_W'(1);
            OP_REMOVE:  fill_next = fill_reg - FILL_W'(1);
            OP_NONE,
            OP_SETDATA: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            fill_reg <= '0;
        end else begin
            hit_reg  <= hit_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        data_reg <= data_next;
    end

    assign hit  = hit_reg;
    assign idx  = idx_reg;
    assign data = data_reg;
    assign fill = fill_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count above slot count");

    a_write_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_WRITE) |-> (fill_reg < FILL_MAX) && (FILL_W'(pos) == fill_reg))
        else $error("insert not at end of packed row");

    a_remove_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_REMOVE) |-> (FILL_W'(pos) < fill_reg))
        else $error("remove outside valid cells");

endmodule
